### rtl/lkda_pkg.sv
package lkda_pkg;

  localparam int SampleW = 10;
  localparam int NumKeys = 4;
  localparam int NowW    = 32;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [1:0]         key_idx_t;
  typedef logic [2:0]         key_code_t;

  localparam key_code_t NoKey = 3'd4;

  // key windows, checked in index order, first hit wins
  localparam sample_t WinLo [NumKeys] = '{10'd0, 10'd500, 10'd324, 10'd735};
  localparam sample_t WinHi [NumKeys] = '{10'd5, 10'd510, 10'd330, 10'd745};

  typedef enum logic [1:0] {
    RegThreshold    = 2'd0,
    RegInitInterval = 2'd1,
    RegIntervalStep = 2'd2
  } reg_idx_t;

  localparam logic [7:0]  ThresholdReset    = 8'd10;
  localparam logic [15:0] InitIntervalReset = 16'd300;
  localparam logic [15:0] IntervalStepReset = 16'd70;

  typedef struct packed {
    logic     hit;
    key_idx_t key;
  } match_t;

endpackage

### rtl/lkda_match.sv
module lkda_match (
  input  lkda_pkg::sample_t sample,
  output lkda_pkg::match_t  match
);

  always_comb begin
    match.hit = 1'b0;
    match.key = '0;
    // walk down so the lowest matching window ends up selected
    for (int i = lkda_pkg::NumKeys - 1; i >= 0; i--) begin
      if (sample >= lkda_pkg::WinLo[i] && sample <= lkda_pkg::WinHi[i]) begin
        match.hit = 1'b1;
        match.key = lkda_pkg::key_idx_t'(i);
      end
    end
  end

endmodule

### rtl/ladder_keypad_debounce_autorepeat.sv
// Resistor-ladder keypad decoder: each poll carries a 10-bit ladder sample and a
// millisecond timestamp, and produces exactly one key_code (0 to 3, or 4 for no
// report). A key is reported once its debounce count reaches the threshold, then
// again whenever the poll time passes the stored press time plus the repeat wait,
// which shrinks by interval_step after every repeat unless below the step, and
// reloads on release. The block takes one poll per clock while the output is not
// stalled; a poll is decoded in the cycle after it is accepted, its result goes to
// an output register, and state updates in a single stage. Configuration writes
// are always accepted and should be made while no poll is in flight.
module ladder_keypad_debounce_autorepeat #(
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // sample [9:0], now_ms [41:10], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // key_code [2:0], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef logic [TIME_BITS-1:0] stamp_t;

  // configuration
  logic [7:0]  press_threshold;
  logic [15:0] initial_interval;
  logic [15:0] interval_step;

  // input register
  logic                  in_valid;
  lkda_pkg::sample_t     in_sample;
  logic [lkda_pkg::NowW-1:0] in_now;

  // output register
  logic                  out_valid;
  lkda_pkg::key_code_t   out_key;

  // keypad state
  logic [7:0]  debounce_count;
  logic        waiting;
  stamp_t      press_stamp [lkda_pkg::NumKeys];
  logic [15:0] repeat_interval;

  logic [7:0]  debounce_count_next;
  logic        waiting_next;
  logic [15:0] repeat_interval_next;
  logic        stamp_we;
  lkda_pkg::key_code_t key_next;

  logic            advance;
  lkda_pkg::match_t match;
  logic [7:0]      cnt_inc;
  logic            qualified;
  logic [63:0]     now_wide;
  stamp_t          now_t;
  stamp_t          deadline;
  logic            expired;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_threshold  <= lkda_pkg::ThresholdReset;
      initial_interval <= lkda_pkg::InitIntervalReset;
      interval_step    <= lkda_pkg::IntervalStepReset;
    end else if (cfg_valid) begin
      unique case (lkda_pkg::reg_idx_t'(cfg_index))
        lkda_pkg::RegThreshold:    press_threshold  <= cfg_data[7:0];
        lkda_pkg::RegInitInterval: initial_interval <= cfg_data;
        lkda_pkg::RegIntervalStep: interval_step    <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshakes
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_key};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_sample <= s_axis_tdata[9:0];
      in_now    <= s_axis_tdata[41:10];
    end
  end

  lkda_match u_match (
    .sample (in_sample),
    .match  (match)
  );

  assign now_wide  = {32'b0, in_now};
  assign now_t     = now_wide[TIME_BITS-1:0];
  assign cnt_inc   = (debounce_count == 8'hFF) ? 8'hFF : debounce_count + 8'd1;
  assign qualified = cnt_inc >= press_threshold;
  assign deadline  = press_stamp[match.key] + TIME_BITS'(repeat_interval);
  assign expired   = now_t > deadline;

  always_comb begin
    debounce_count_next  = debounce_count;
    waiting_next         = waiting;
    repeat_interval_next = repeat_interval;
    stamp_we             = 1'b0;
    key_next             = lkda_pkg::NoKey;
    if (!match.hit) begin
      debounce_count_next  = '0;
      waiting_next         = 1'b0;
      repeat_interval_next = initial_interval;
    end else begin
      debounce_count_next = cnt_inc;
      if (qualified) begin
        if (!waiting) begin
          stamp_we     = 1'b1;
          waiting_next = 1'b1;
          key_next     = {1'b0, match.key};
        end else if (expired) begin
          waiting_next = 1'b0;
          if (repeat_interval >= interval_step) begin
            repeat_interval_next = repeat_interval - interval_step;
          end
          key_next = {1'b0, match.key};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_count  <= '0;
      waiting         <= 1'b0;
      repeat_interval <= lkda_pkg::InitIntervalReset;
      for (int i = 0; i < lkda_pkg::NumKeys; i++) begin
        press_stamp[i] <= '0;
      end
    end else if (advance) begin
      debounce_count  <= debounce_count_next;
      waiting         <= waiting_next;
      repeat_interval <= repeat_interval_next;
      if (stamp_we) begin
        press_stamp[match.key] <= now_t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_key <= key_next;
    end
  end

  // a wait in progress always comes from a counted press
  a_wait_has_count: assert property (@(posedge clk) disable iff (rst)
    waiting |-> debounce_count != 8'd0)
    else $error("waiting set with zero debounce count");

  // a release clears the press state
  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    advance && !match.hit |=> debounce_count == 8'd0 && !waiting
      && repeat_interval == $past(initial_interval))
    else $error("release did not clear press state");

  // the result register only ever holds a key or the no-key code
  a_key_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_key <= lkda_pkg::NoKey)
    else $error("key code out of range");

  // a new press report always stamps and arms the repeat wait
  a_first_report: assert property (@(posedge clk) disable iff (rst)
    advance && stamp_we |=> waiting && out_key == {1'b0, $past(match.key)})
    else $error("first report did not arm repeat");

endmodule

### bench/keypad_report_checker.sv
`timescale 1ns / 100ps

module keypad_report_checker
  import lkda_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          awaited,
  output int          key_reports
);

  logic [7:0]  threshold_r;
  logic [15:0] init_iv_r;
  logic [15:0] step_r;

  logic [7:0]  bounce_cnt;
  logic        held_wait;
  logic [31:0] stamp_mem [NumKeys];
  logic [15:0] cur_iv;

  key_code_t   code_fifo [$];
  key_code_t   want;

  initial begin
    mismatches  = 0;
    awaited     = 0;
    key_reports = 0;
  end

  function automatic key_code_t predict_code(input sample_t smp, input logic [31:0] now);
    logic        found;
    key_idx_t    key;
    logic [31:0] due;
    found = 1'b0;
    key   = '0;
    for (int k = 0; k < NumKeys; k++) begin
      if (!found && smp >= WinLo[k] && smp <= WinHi[k]) begin
        found = 1'b1;
        key   = key_idx_t'(k);
      end
    end
    if (!found) begin
      bounce_cnt = '0;
      held_wait  = 1'b0;
      cur_iv     = init_iv_r;
      return NoKey;
    end
    if (bounce_cnt != 8'hFF) bounce_cnt++;
    if (bounce_cnt < threshold_r) return NoKey;
    if (!held_wait) begin
      stamp_mem[key] = now;
      held_wait      = 1'b1;
      return {1'b0, key};
    end
    // deadline wraps at the time width
    due = stamp_mem[key] + 32'(cur_iv);
    if (now > due) begin
      held_wait = 1'b0;
      if (cur_iv >= step_r) cur_iv = cur_iv - step_r;
      return {1'b0, key};
    end
    return NoKey;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      threshold_r = ThresholdReset;
      init_iv_r   = InitIntervalReset;
      step_r      = IntervalStepReset;
      bounce_cnt  = '0;
      held_wait   = 1'b0;
      cur_iv      = InitIntervalReset;
      for (int k = 0; k < NumKeys; k++) stamp_mem[k] = '0;
      code_fifo.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (code_fifo.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: key_code %0d arrived with no poll waiting", $time, m_tdata[2:0]);
        end else begin
          want = code_fifo.pop_front();
          if (m_tdata[2:0] !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: key_code expected %0d, got %0d", $time, want, m_tdata[2:0]);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          RegThreshold:    threshold_r = cfg_data[7:0];
          RegInitInterval: init_iv_r   = cfg_data;
          RegIntervalStep: step_r      = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        want = predict_code(s_tdata[9:0], s_tdata[41:10]);
        if (want != NoKey) key_reports++;
        code_fifo.push_back(want);
      end
    end
    awaited <= code_fifo.size();
  end

endmodule

### bench/ladder_keypad_debounce_autorepeat_tb.sv
`timescale 1ns / 100ps

module ladder_keypad_debounce_autorepeat_tb;
  import lkda_pkg::*;

  // no register behind this index, writes must be dropped
  localparam logic [1:0] RegSpare = 2'd3;

  localparam int NumDirected = 19;
  localparam sample_t DirSample [NumDirected] = '{
    10'd0,   10'd5,   10'd5,   10'd3,   10'd6,   10'd500, 10'd510, 10'd499,
    10'd324, 10'd745, 10'd746, 10'd323, 10'd331, 10'd734, 10'd511, 10'd1023,
    10'd735, 10'd740, 10'd0
  };
  localparam logic [31:0] DirTime [NumDirected] = '{
    32'd100, 32'd105, 32'd106, 32'd107, 32'd108, 32'd200, 32'd206, 32'd207,
    32'd300, 32'd301, 32'd302, 32'd303, 32'd304, 32'd305, 32'd306, 32'd307,
    32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd0
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;    // sample [9:0], now_ms [41:10], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // key_code [2:0], zero pad
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int          mismatches;
  int          awaited;
  int          key_reports;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          polls_sent     = 0;
  int          settings_used  = 0;
  logic [31:0] clock_ms;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ladder_keypad_debounce_autorepeat u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  keypad_report_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_axis_tvalid),
    .s_tready    (s_axis_tready),
    .s_tdata     (s_axis_tdata),
    .m_tvalid    (m_axis_tvalid),
    .m_tready    (m_axis_tready),
    .m_tdata     (m_axis_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .awaited     (awaited),
    .key_reports (key_reports)
  );

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic send_poll(input sample_t smp, input logic [31:0] now);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, now, smp};
    do @(posedge clk); while (!s_axis_tready);
    polls_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // drain every poll in flight, then rewrite all registers
  task automatic configure(input logic [7:0] thr, input logic [15:0] iv,
                           input logic [15:0] stp);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (awaited != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(RegSpare, 16'($urandom));
    // upper byte of a threshold write is don't care
    write_reg(RegThreshold, {8'($urandom), thr});
    write_reg(RegInitInterval, iv);
    write_reg(RegIntervalStep, stp);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [31:0] next_ms(input int max_dt);
    if ($urandom_range(0, 31) == 0) clock_ms = clock_ms + $urandom;
    else clock_ms = clock_ms + $urandom_range(0, max_dt);
    return clock_ms;
  endfunction

  function automatic sample_t key_sample(input key_idx_t k);
    return WinLo[k] + sample_t'($urandom_range(0, WinHi[k] - WinLo[k]));
  endfunction

  // mostly held keys with in-window jitter, some releases and window edges
  task automatic run_presses(input int n_items, input int min_hold, input int max_hold,
                             input int max_dt);
    int       sent;
    int       pick;
    int       len;
    key_idx_t k;
    sample_t  edge_smp;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        k   = key_idx_t'($urandom_range(0, NumKeys - 1));
        len = $urandom_range(min_hold, max_hold);
        // keep the phase close to its item budget
        if (len > n_items - sent) len = n_items - sent;
        for (int i = 0; i < len; i++) begin
          // key change without a release in between
          if ($urandom_range(0, 15) == 0) k = key_idx_t'($urandom_range(0, NumKeys - 1));
          send_poll(key_sample(k), next_ms(max_dt));
        end
        sent += len;
      end else if (pick < 9) begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) send_poll(sample_t'($urandom), next_ms(max_dt));
        sent += len;
      end else begin
        k = key_idx_t'($urandom_range(0, NumKeys - 1));
        case ($urandom_range(0, 3))
          0:       edge_smp = WinLo[k] - 1'b1;
          1:       edge_smp = WinLo[k];
          2:       edge_smp = WinHi[k];
          default: edge_smp = WinHi[k] + 1'b1;
        endcase
        send_poll(edge_smp, next_ms(max_dt));
        sent++;
      end
    end
  endtask

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: window edges, repeat timing, key change, time wrap
    configure(8'd1, 16'd5, 16'd3);
    for (int i = 0; i < NumDirected; i++) send_poll(DirSample[i], DirTime[i]);

    // zero threshold qualifies on the first matched poll
    configure(8'd0, 16'd0, 16'hFFFF);
    send_poll(10'd327, 32'd500);
    send_poll(10'd327, 32'd500);
    send_poll(10'd1023, 32'd1);

    clock_ms = $urandom;

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    configure(8'd3, 16'd40, 16'd7);
    run_presses(220, 1, 40, 12);

    send_idle_pct  = 78;
    recv_stall_pct = 0;
    configure(8'd1, 16'd0, 16'd0);
    run_presses(200, 1, 30, 3);

    send_idle_pct  = 0;
    recv_stall_pct = 78;
    configure(8'd0, 16'hFFFF, 16'hFFFF);
    run_presses(200, 1, 60, 20000);

    // long holds so the debounce count saturates
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    configure(8'd255, 16'd100, 16'd30);
    run_presses(300, 260, 300, 40);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    configure(8'd10, 16'd300, 16'd70);
    run_presses(130, 5, 40, 80);

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (awaited != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d polls sent under %0d register settings", polls_sent, settings_used);
    $display("%0d key reports predicted, %0d mismatches", key_reports, mismatches);
    if (mismatches == 0 && awaited == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/lkda_pkg.sv
rtl/lkda_match.sv
rtl/ladder_keypad_debounce_autorepeat.sv
bench/keypad_report_checker.sv
bench/ladder_keypad_debounce_autorepeat_tb.sv
